@@ hw/rtl/btp_pkg.sv @@
// Shared types and constants for the backup transfer protocol core.
// No dependencies; every other file in hw/rtl imports this package.

package btp_pkg;

    // Counter width for block totals and the running block index
    localparam int COUNT_WIDTH = 9;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam int LIMIT_WIDTH    = 9;
    localparam int CFG_ADDR_WIDTH = 2;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_ONE_RESET   = 9'd384;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_TWO_RESET   = 9'd256;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_THREE_RESET = 9'd128;

    // Configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LIMIT_ONE   = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LIMIT_TWO   = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LIMIT_THREE = 2'd2;

    // Event kinds
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MSG    = 2'd1;
    localparam logic [1:0] CMD_ANSWER = 2'd2;

    // Received op codes
    localparam logic [2:0] OP_HELLO      = 3'd0;
    localparam logic [2:0] OP_CONFIRM    = 3'd1;
    localparam logic [2:0] OP_BLOCK_ACK  = 3'd2;
    localparam logic [2:0] OP_BYE        = 3'd3;
    localparam logic [2:0] OP_DATA_ERROR = 3'd4;

    // User answers
    localparam logic [1:0] ANS_YES = 2'd0;
    localparam logic [1:0] ANS_NO  = 2'd1;
    localparam logic [1:0] ANS_OK  = 2'd2;

    // Outgoing message kinds
    localparam logic [2:0] SEND_NONE  = 3'd0;
    localparam logic [2:0] SEND_HELLO = 3'd1;
    localparam logic [2:0] SEND_START = 3'd2;
    localparam logic [2:0] SEND_BLOCK = 3'd3;
    localparam logic [2:0] SEND_BYE   = 3'd4;

    // Phase codes as seen on the result
    localparam logic [2:0] PH_ASK     = 3'd0;
    localparam logic [2:0] PH_HELLO   = 3'd1;
    localparam logic [2:0] PH_CONFIRM = 3'd2;
    localparam logic [2:0] PH_XFER    = 3'd3;
    localparam logic [2:0] PH_BYE     = 3'd4;
    localparam logic [2:0] PH_SUCCESS = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_DATA       = 3'd1;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd2;
    localparam logic [2:0] ERR_BAD_BANK   = 3'd3;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd4;
    localparam logic [2:0] ERR_MISMATCH   = 3'd5;
    localparam logic [2:0] ERR_ORDER      = 3'd6;

    localparam int S_TDATA_WIDTH = 48;
    localparam int M_TDATA_WIDTH = 24;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  op_code;
        logic [7:0]  msg_bank;
        logic [31:0] msg_number;
        logic [1:0]  user_answer;
    } t_item;

    typedef struct packed {
        logic [2:0] send_kind;
        logic [1:0] send_bank;
        logic [8:0] send_block;
        logic [2:0] phase_now;
        logic [2:0] error_code;
        logic       leave;
        logic       link_close;
    } t_result;

endpackage

@@ hw/rtl/btp_in_stage.sv @@
// Input register of the backup transfer protocol core.
// Depends on btp_pkg for the item type.

module btp_in_stage
    import btp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ hw/rtl/btp_fsm.sv @@
// Protocol state, limit registers and the per-item step logic.
// Depends on btp_pkg for codes, limits and the item/result types.

module btp_fsm
    import btp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [LIMIT_WIDTH-1:0]    i_cfg_wdata,
    input  logic                      i_fire,
    input  t_item                     i_item,
    output t_result                   o_result
);

    typedef enum logic [2:0] {
        ST_ASK     = PH_ASK,
        ST_HELLO   = PH_HELLO,
        ST_CONFIRM = PH_CONFIRM,
        ST_XFER    = PH_XFER,
        ST_BYE     = PH_BYE,
        ST_SUCCESS = PH_SUCCESS,
        ST_DONE    = PH_DONE,
        ST_ERROR   = PH_ERROR
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_bank, n_bank;
    logic [COUNT_WIDTH-1:0] r_total, n_total;
    logic [COUNT_WIDTH-1:0] r_counter, n_counter;
    logic                   r_awaiting, n_awaiting;
    logic [2:0]             r_last_error, n_last_error;

    logic [LIMIT_WIDTH-1:0] r_limit_one, r_limit_two, r_limit_three;
    logic [LIMIT_WIDTH-1:0] lim;
    logic                   bad_bank, too_many;
    logic [2:0]             kind;
    logic [1:0]             sbank;
    logic [COUNT_WIDTH-1:0] sblock;
    logic                   leave, close;

    always_comb begin
        priority if (i_item.msg_bank == 8'd1) begin
            lim = r_limit_one;
        end else if (i_item.msg_bank == 8'd2) begin
            lim = r_limit_two;
        end else begin
            lim = r_limit_three;
        end
        bad_bank = (i_item.msg_bank == 8'd0) || (i_item.msg_bank > 8'd3);
        too_many = (i_item.msg_number > 32'(lim))
                || (i_item.msg_number > 32'(COUNT_MAX));
    end

    always_comb begin
        n_phase      = r_phase;
        n_bank       = r_bank;
        n_total      = r_total;
        n_counter    = r_counter;
        n_awaiting   = r_awaiting;
        n_last_error = r_last_error;
        kind         = SEND_NONE;
        sbank        = '0;
        sblock       = '0;
        leave        = 1'b0;
        close        = 1'b0;

        unique case (i_item.command)
            CMD_TICK: begin
                if (r_phase == ST_HELLO) begin
                    kind = SEND_HELLO;
                end else if (r_phase == ST_XFER) begin
                    if (r_counter >= r_total) begin
                        kind    = SEND_BYE;
                        n_phase = ST_BYE;
                    end else if (!r_awaiting) begin
                        kind       = SEND_BLOCK;
                        sbank      = r_bank;
                        sblock     = r_counter;
                        n_awaiting = 1'b1;
                    end
                end
            end
            CMD_MSG: begin
                unique case (r_phase)
                    ST_HELLO: begin
                        if (i_item.op_code == OP_DATA_ERROR) begin
                            n_phase = ST_ERROR; n_last_error = ERR_DATA;
                        end else if (i_item.op_code == OP_HELLO) begin
                            kind    = SEND_START;
                            n_phase = ST_CONFIRM;
                        end else begin
                            n_phase = ST_ERROR; n_last_error = ERR_UNEXPECTED;
                        end
                    end
                    ST_CONFIRM: begin
                        if (i_item.op_code == OP_DATA_ERROR) begin
                            n_phase = ST_ERROR; n_last_error = ERR_DATA;
                        end else if (i_item.op_code == OP_CONFIRM) begin
                            n_bank  = i_item.msg_bank[1:0];
                            n_total = i_item.msg_number[COUNT_WIDTH-1:0];
                            if (bad_bank) begin
                                n_phase = ST_ERROR; n_last_error = ERR_BAD_BANK;
                            end else if (too_many) begin
                                n_phase = ST_ERROR; n_last_error = ERR_TOO_MANY;
                            end else begin
                                n_phase = ST_XFER;
                            end
                        end else begin
                            n_phase = ST_ERROR; n_last_error = ERR_UNEXPECTED;
                        end
                    end
                    ST_XFER: begin
                        // a message is only looked at while an ack is awaited and blocks are left
                        if (r_counter < r_total && r_awaiting) begin
                            if (i_item.op_code == OP_DATA_ERROR) begin
                                n_phase = ST_ERROR; n_last_error = ERR_DATA;
                            end else if (i_item.op_code == OP_BLOCK_ACK) begin
                                if (i_item.msg_bank != 8'(r_bank)) begin
                                    n_phase = ST_ERROR; n_last_error = ERR_MISMATCH;
                                end else if (i_item.msg_number != 32'(r_counter)) begin
                                    n_phase = ST_ERROR; n_last_error = ERR_ORDER;
                                end
                                // counter advances even on a bad ack
                                n_counter  = r_counter + 1'b1;
                                n_awaiting = 1'b0;
                            end else begin
                                n_phase = ST_ERROR; n_last_error = ERR_UNEXPECTED;
                            end
                        end
                    end
                    ST_BYE: begin
                        if (i_item.op_code == OP_DATA_ERROR) begin
                            n_phase = ST_ERROR; n_last_error = ERR_DATA;
                        end else if (i_item.op_code == OP_BYE) begin
                            n_phase = ST_SUCCESS;
                        end else begin
                            n_phase = ST_ERROR; n_last_error = ERR_UNEXPECTED;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_ANSWER: begin
                if (r_phase == ST_ASK) begin
                    if (i_item.user_answer == ANS_YES) begin
                        n_phase = ST_HELLO;
                    end else if (i_item.user_answer == ANS_NO) begin
                        leave = 1'b1;
                    end
                end else if (r_phase == ST_SUCCESS || r_phase == ST_ERROR) begin
                    if (i_item.user_answer == ANS_OK) begin
                        n_phase = ST_DONE;
                        close   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.send_kind  = kind;
        o_result.send_bank  = sbank;
        o_result.send_block = 9'(sblock);
        o_result.phase_now  = n_phase;
        o_result.error_code = n_last_error;
        o_result.leave      = leave;
        o_result.link_close = close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ST_ASK;
            r_bank       <= '0;
            r_total      <= '0;
            r_counter    <= '0;
            r_awaiting   <= 1'b0;
            r_last_error <= ERR_NONE;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_bank       <= n_bank;
            r_total      <= n_total;
            r_counter    <= n_counter;
            r_awaiting   <= n_awaiting;
            r_last_error <= n_last_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_one   <= LIMIT_ONE_RESET;
            r_limit_two   <= LIMIT_TWO_RESET;
            r_limit_three <= LIMIT_THREE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_LIMIT_ONE) begin
                r_limit_one <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_LIMIT_TWO) begin
                r_limit_two <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_LIMIT_THREE) begin
                r_limit_three <= i_cfg_wdata;
            end
        end
    end

endmodule

@@ hw/rtl/btp_out_stage.sv @@
// Result register of the backup transfer protocol core.
// Depends on btp_pkg for the result type.

module btp_out_stage
    import btp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hw/rtl/backup_transfer_protocol_fsm_core.sv @@
// Top level of the backup transfer protocol core (device side).
// Depends on btp_pkg, btp_in_stage, btp_fsm and btp_out_stage.
//
// Usage:
//  - Slave channel s_*: one event item per handshake. s_tuser carries the
//    event kind (tick, message received, user answer); s_tdata carries the
//    op code, bank, number and user answer of that event.
//  - Master channel m_*: exactly one result item per event. m_tuser carries
//    the kind of message to send; m_tdata the block bank/index, the phase
//    after the event, the sticky error code and the leave/link-close flags.
//  - Config port: i_cfg_we writes i_cfg_wdata into the bank limit selected by
//    i_cfg_addr (0: bank 1, 1: bank 2, 2: bank 3) in the same cycle. Write
//    only while no event is in flight.
// Timing: an accepted item is held in the input register while its step logic
// runs, and the result is loaded into the output register, which drives m_*;
// an item stalled behind a full output register stays in the input register.
// One item per cycle is sustained while m_tready stays high;
// the protocol state is updated in the same cycle the result is loaded.
// Reset (synchronous, active low) empties both registers, puts the protocol
// in the ask phase, clears counters and error, and restores default limits.
// If m_tready is held low, the output register holds its item, the input
// register fills behind it, and then s_tready drops until the sink takes.

module backup_transfer_protocol_fsm_core
    import btp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [2:0] op_code, [10:3] msg_bank, [42:11] msg_number, [44:43] user_answer
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]                s_tuser,

    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [1:0] send_bank, [10:2] send_block, [13:11] phase_now,
    // [16:14] error_code, [17] leave, [18] link_close
    output logic [M_TDATA_WIDTH-1:0]  m_tdata,
    // [2:0] send_kind
    output logic [2:0]                m_tuser,

    input  logic                      i_cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [LIMIT_WIDTH-1:0]    i_cfg_wdata
);

    t_item   in_item, held_item;
    t_result step_result, out_result;
    logic    held_valid, out_can_load, take;

    // unpack the slave side into the item struct
    always_comb begin
        in_item.command     = s_tuser;
        in_item.op_code     = s_tdata[2:0];
        in_item.msg_bank    = s_tdata[10:3];
        in_item.msg_number  = s_tdata[42:11];
        in_item.user_answer = s_tdata[44:43];
    end

    // the held item steps the FSM when the output register can take its result
    assign take = held_valid && out_can_load;

    btp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_item  (in_item),
        .i_take  (take),
        .o_ready (s_tready),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    btp_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (take),
        .i_item      (held_item),
        .o_result    (step_result)
    );

    btp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_result   (step_result),
        .i_ready    (m_tready),
        .o_can_load (out_can_load),
        .o_valid    (m_tvalid),
        .o_result   (out_result)
    );

    // pack the master side, zero fill to whole bytes
    assign m_tuser = out_result.send_kind;
    assign m_tdata = {5'b0,
                      out_result.link_close,
                      out_result.leave,
                      out_result.error_code,
                      out_result.phase_now,
                      out_result.send_block,
                      out_result.send_bank};

endmodule

@@ hw/rtl/btp_checker.sv @@
// Port-level checks for the backup transfer protocol core, bound to the top.
// Depends on btp_pkg for message kind and phase codes.

module btp_checker
    import btp_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [M_TDATA_WIDTH-1:0] m_tdata,
    input logic [2:0]               m_tuser
);

    // result register is emptied by reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // bank and block index are only reported with a block message
    a_block_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != SEND_BLOCK) |-> (m_tdata[10:0] == 11'd0))
        else $error("block fields set without a block message");

    // closing the link means the done phase was entered
    a_close_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[18]) |-> (m_tdata[13:11] == PH_DONE))
        else $error("link close outside the done phase");

    // leaving keeps the ask phase and sends nothing
    a_leave_ask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[17]) |-> (m_tdata[13:11] == PH_ASK && m_tuser == SEND_NONE))
        else $error("leave outside the ask phase");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind backup_transfer_protocol_fsm_core btp_checker u_btp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ tb/sv/backup_transfer_protocol_fsm_core_tb.sv @@
// Self-checking testbench for backup_transfer_protocol_fsm_core.
// Needs btp_pkg and the core RTL; runs one backup session per seed
// against a cycle-free predictor of the protocol state machine.

module backup_transfer_protocol_fsm_core_tb;
    import btp_pkg::*;

    // Codes the package leaves unnamed: the fourth event kind, the
    // fourth answer and the fourth register index do nothing.
    localparam logic [1:0]                CMD_UNUSED     = 2'd3;
    localparam logic [1:0]                ANS_UNUSED     = 2'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ADDR_SPARE = 2'd3;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 120;
    localparam int PRINT_LIMIT     = 50;
    localparam int ITEM_TARGET     = 1250;

    // How this seed's session ends; everything but END_CLEAN drives
    // the block into its error phase at one chosen point.
    typedef enum int {
        END_CLEAN,
        END_HELLO_FAULT,
        END_CONFIRM_FAULT,
        END_TOO_MANY,
        END_ACK_DATA,
        END_ACK_BANK,
        END_ACK_ORDER,
        END_ACK_OP,
        END_BYE_FAULT
    } t_session_end;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      s_tvalid    = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata     = '0;
    logic [1:0]                s_tuser     = '0;
    logic                      m_tvalid;
    logic                      m_tready    = 1'b0;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;
    logic [2:0]                m_tuser;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] i_cfg_addr  = '0;
    logic [LIMIT_WIDTH-1:0]    i_cfg_wdata = '0;

    always #10 i_clk = ~i_clk;

    backup_transfer_protocol_fsm_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the protocol state and limits
    // ------------------------------------------------------------------
    logic [2:0]             ph        = PH_ASK;
    logic [1:0]             cur_bank  = '0;
    logic [COUNT_WIDTH-1:0] blk_total = '0;
    logic [COUNT_WIDTH-1:0] blk_count = '0;
    logic                   ack_wait  = 1'b0;
    logic [2:0]             err       = ERR_NONE;
    logic [LIMIT_WIDTH-1:0] lim_one   = LIMIT_ONE_RESET;
    logic [LIMIT_WIDTH-1:0] lim_two   = LIMIT_TWO_RESET;
    logic [LIMIT_WIDTH-1:0] lim_three = LIMIT_THREE_RESET;

    t_item        pending_events[$];
    t_result      expected_results[$];
    t_item        cur_event;
    t_session_end session_end;

    int unsigned mismatch_count  = 0;
    int unsigned events_accepted = 0;
    int unsigned results_seen    = 0;
    int unsigned idle_cycles     = 0;

    // Error is sticky: only reset clears the code.
    function automatic void enter_error(input logic [2:0] code);
        ph  = PH_ERROR;
        err = code;
    endfunction

    // One event in, one result out; updates the predictor state.
    function automatic t_result step_protocol(input t_item ev);
        t_result                r;
        logic [LIMIT_WIDTH-1:0] lim;
        r = '0;
        case (ev.command)
            CMD_TICK: begin
                if (ph == PH_HELLO) begin
                    r.send_kind = SEND_HELLO;
                end else if (ph == PH_XFER) begin
                    if (blk_count >= blk_total) begin
                        r.send_kind = SEND_BYE;
                        ph          = PH_BYE;
                    end else if (!ack_wait) begin
                        r.send_kind  = SEND_BLOCK;
                        r.send_bank  = cur_bank;
                        r.send_block = blk_count;
                        ack_wait     = 1'b1;
                    end
                end
            end
            CMD_MSG: begin
                case (ph)
                    PH_HELLO: begin
                        if (ev.op_code == OP_DATA_ERROR) enter_error(ERR_DATA);
                        else if (ev.op_code == OP_HELLO) begin
                            r.send_kind = SEND_START;
                            ph          = PH_CONFIRM;
                        end else enter_error(ERR_UNEXPECTED);
                    end
                    PH_CONFIRM: begin
                        if (ev.op_code == OP_DATA_ERROR) enter_error(ERR_DATA);
                        else if (ev.op_code == OP_CONFIRM) begin
                            // bank and count are latched even when rejected
                            cur_bank  = ev.msg_bank[1:0];
                            blk_total = ev.msg_number[COUNT_WIDTH-1:0];
                            case (ev.msg_bank)
                                8'd1:    lim = lim_one;
                                8'd2:    lim = lim_two;
                                default: lim = lim_three;
                            endcase
                            // full-width checks on bank and count
                            if (ev.msg_bank < 8'd1 || ev.msg_bank > 8'd3)
                                enter_error(ERR_BAD_BANK);
                            else if (ev.msg_number > 32'(lim)
                                     || ev.msg_number > 32'(COUNT_MAX))
                                enter_error(ERR_TOO_MANY);
                            else
                                ph = PH_XFER;
                        end else enter_error(ERR_UNEXPECTED);
                    end
                    PH_XFER: begin
                        // only acts while an ack is owed and blocks remain
                        if (blk_count < blk_total && ack_wait) begin
                            if (ev.op_code == OP_DATA_ERROR) enter_error(ERR_DATA);
                            else if (ev.op_code == OP_BLOCK_ACK) begin
                                if (ev.msg_bank != 8'(cur_bank))
                                    enter_error(ERR_MISMATCH);
                                else if (ev.msg_number != 32'(blk_count))
                                    enter_error(ERR_ORDER);
                                // counter moves on even after a bad ack
                                blk_count = blk_count + 1'b1;
                                ack_wait  = 1'b0;
                            end else enter_error(ERR_UNEXPECTED);
                        end
                    end
                    PH_BYE: begin
                        if (ev.op_code == OP_DATA_ERROR) enter_error(ERR_DATA);
                        else if (ev.op_code == OP_BYE) ph = PH_SUCCESS;
                        else enter_error(ERR_UNEXPECTED);
                    end
                    default: ;
                endcase
            end
            CMD_ANSWER: begin
                if (ph == PH_ASK) begin
                    if (ev.user_answer == ANS_YES) ph = PH_HELLO;
                    else if (ev.user_answer == ANS_NO) r.leave = 1'b1;
                end else if (ph == PH_SUCCESS || ph == PH_ERROR) begin
                    if (ev.user_answer == ANS_OK) begin
                        ph           = PH_DONE;
                        r.link_close = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.phase_now  = ph;
        r.error_code = err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got_v,
                               input int unsigned want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    endtask

    // ------------------------------------------------------------------
    // Event builders: unused fields always carry random bits
    // ------------------------------------------------------------------
    function automatic t_item any_event();
        t_item ev;
        ev.command     = 2'($urandom_range(0, 3));
        ev.op_code     = 3'($urandom_range(0, 7));
        ev.msg_bank    = 8'($urandom_range(0, 255));
        ev.msg_number  = $urandom;
        ev.user_answer = 2'($urandom_range(0, 3));
        return ev;
    endfunction

    task automatic push_tick();
        t_item ev;
        ev = any_event();
        ev.command = CMD_TICK;
        pending_events.push_back(ev);
    endtask

    task automatic push_msg(input logic [2:0] op, input logic [7:0] mbank,
                            input logic [31:0] num);
        t_item ev;
        ev = any_event();
        ev.command    = CMD_MSG;
        ev.op_code    = op;
        ev.msg_bank   = mbank;
        ev.msg_number = num;
        pending_events.push_back(ev);
    endtask

    task automatic push_answer(input logic [1:0] ans);
        t_item ev;
        ev = any_event();
        ev.command     = CMD_ANSWER;
        ev.user_answer = ans;
        pending_events.push_back(ev);
    endtask

    task automatic push_other();
        t_item ev;
        ev = any_event();
        ev.command = CMD_UNUSED;
        pending_events.push_back(ev);
    endtask

    // Filler that must not move the protocol in the current phase.
    task automatic push_noise(input bit tick_ok, input bit msg_ok, input bit ok_ans_ok);
        int unsigned pick;
        logic [1:0]  ans;
        pick = $urandom_range(0, 3);
        if (pick == 0 && !tick_ok) pick = 3;
        if (pick == 1 && !msg_ok) pick = 3;
        case (pick)
            0: push_tick();
            1: push_msg(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom);
            2: begin
                ans = 2'($urandom_range(0, 3));
                if (!ok_ans_ok && ans == ANS_OK) ans = ANS_UNUSED;
                push_answer(ans);
            end
            default: push_other();
        endcase
    endtask

    // ------------------------------------------------------------------
    // Config helpers; only called with the block idle
    // ------------------------------------------------------------------
    task automatic write_limit(input logic [CFG_ADDR_WIDTH-1:0] idx,
                               input logic [LIMIT_WIDTH-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_LIMIT_ONE:   lim_one   = val;
            CFG_LIMIT_TWO:   lim_two   = val;
            CFG_LIMIT_THREE: lim_three = val;
            default: ;
        endcase
    endtask

    task automatic end_cfg();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Everything sent and every result back, then a short settle.
    task automatic wait_drained();
        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: pops pending items, bursts with random gaps. The result
    // is predicted at the edge where the item is taken.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin : drive_proc
        logic nxt_valid;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(step_protocol(cur_event));
                events_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_events.size() != 0) begin
                    cur_event = pending_events.pop_front();
                    nxt_valid = 1'b1;
                    // tdata: op, bank, number, answer from bit 0 up
                    s_tdata <= {{(S_TDATA_WIDTH-45){1'b0}}, cur_event.user_answer,
                                cur_event.msg_number, cur_event.msg_bank,
                                cur_event.op_code};
                    s_tuser <= cur_event.command;
                    if (burst_left <= 1) begin
                        // now and then a long stretch with no gaps
                        burst_left = ($urandom_range(0, 7) == 0) ? 100
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction and
    // drives m_tready from its own stall pattern, with one long hold.
    // ------------------------------------------------------------------
    int unsigned rdy_mode  = 0;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic [7:0]  stall_pat = 8'b1011_0010;

    always @(posedge i_clk) begin : sink_proc
        t_result got;
        t_result want;
        logic    rdy;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.send_kind  = m_tuser;
                got.send_bank  = m_tdata[1:0];
                got.send_block = m_tdata[10:2];
                got.phase_now  = m_tdata[13:11];
                got.error_code = m_tdata[16:14];
                got.leave      = m_tdata[17];
                got.link_close = m_tdata[18];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no event outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("send_kind",  32'(got.send_kind),  32'(want.send_kind));
                    check_field("send_bank",  32'(got.send_bank),  32'(want.send_bank));
                    check_field("send_block", 32'(got.send_block), 32'(want.send_block));
                    check_field("phase_now",  32'(got.phase_now),  32'(want.phase_now));
                    check_field("error_code", 32'(got.error_code), 32'(want.error_code));
                    check_field("leave",      32'(got.leave),      32'(want.leave));
                    check_field("link_close", 32'(got.link_close), 32'(want.link_close));
                end
                results_seen++;
            end

            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && results_seen >= 100 && pending_events.size() > 40) begin
                // long hold-off with the sender still busy: both
                // registers fill and s_tready has to drop
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end else begin
                    mode_left--;
                end
                stall_pat = {stall_pat[6:0], stall_pat[7]};
                case (rdy_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = stall_pat[0];
                endcase
            end
            m_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("TIMEOUT: no handshake for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed opening, then one long session whose size and
    // ending are picked from the seed. Reset happens only once, so the
    // done phase is terminal and each seed sees one way of finishing.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned            r;
        int unsigned            hello_ticks;
        int unsigned            n_blocks;
        int unsigned            err_at;
        int unsigned            k;
        logic [7:0]             bank_sel;
        logic [7:0]             mb;
        logic [LIMIT_WIDTH-1:0] lim_final;
        logic [31:0]            num;
        logic [2:0]             op;
        bit                     faulted;

        r = $urandom_range(0, 15);
        session_end = (r < 8) ? END_CLEAN : t_session_end'(r - 7);
        bank_sel    = 8'($urandom_range(1, 3));
        hello_ticks = $urandom_range(150, 250);
        // an empty transfer now and then: BYE right after the confirm
        n_blocks    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(300, 511);
        lim_final   = $urandom_range(0, 1) ? LIMIT_WIDTH'(n_blocks)
                                           : LIMIT_WIDTH'($urandom_range(n_blocks, 511));
        err_at      = (n_blocks == 0) ? 0 : $urandom_range(0, n_blocks - 1);
        if (n_blocks == 0 && session_end >= END_ACK_DATA && session_end <= END_ACK_OP)
            session_end = END_CLEAN;
        faulted = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // limits at their extremes right after reset
        write_limit(CFG_LIMIT_ONE, '0);
        write_limit(CFG_LIMIT_TWO, '1);
        write_limit(CFG_LIMIT_THREE, '0);
        end_cfg();

        // ask phase: everything but yes/no is ignored, no sets leave
        push_tick();
        push_other();
        push_msg(OP_DATA_ERROR, '1, '1);
        push_msg(OP_HELLO, '0, '0);
        push_answer(ANS_OK);
        push_answer(ANS_UNUSED);
        push_answer(ANS_NO);
        push_answer(ANS_NO);
        wait_drained();

        // spare index must leave every limit alone
        write_limit(CFG_ADDR_SPARE, LIMIT_WIDTH'($urandom_range(0, 511)));
        write_limit(CFG_LIMIT_ONE, '1);
        write_limit(CFG_LIMIT_TWO, '0);
        write_limit(CFG_LIMIT_THREE, '1);
        end_cfg();

        // hello phase: ticks send HELLO, answers and kind 3 ignored
        push_answer(ANS_YES);
        push_tick();
        push_tick();
        push_answer(ANS_YES);
        push_answer(ANS_NO);
        push_answer(ANS_OK);
        push_other();
        push_tick();
        wait_drained();

        // random part: more HELLO ticks, then the station answers
        for (k = 0; k < hello_ticks; k++) begin
            if ($urandom_range(0, 4) == 0) push_noise(1'b1, 1'b0, 1'b1);
            push_tick();
        end
        if (session_end == END_HELLO_FAULT) begin
            do op = 3'($urandom_range(0, 7)); while (op == OP_HELLO);
            push_msg(op, 8'($urandom_range(0, 255)), $urandom);
            faulted = 1'b1;
        end else begin
            push_msg(OP_HELLO, 8'($urandom_range(0, 255)), $urandom);
            repeat ($urandom_range(1, 6)) push_noise(1'b1, 1'b0, 1'b1);
        end
        wait_drained();

        // limits that the confirm will be checked against
        write_limit(CFG_LIMIT_ONE, LIMIT_WIDTH'($urandom_range(0, 511)));
        write_limit(CFG_LIMIT_TWO, LIMIT_WIDTH'($urandom_range(0, 511)));
        write_limit(CFG_LIMIT_THREE, LIMIT_WIDTH'($urandom_range(0, 511)));
        case (bank_sel)
            8'd1:    write_limit(CFG_LIMIT_ONE, lim_final);
            8'd2:    write_limit(CFG_LIMIT_TWO, lim_final);
            default: write_limit(CFG_LIMIT_THREE, lim_final);
        endcase
        end_cfg();

        if (!faulted) begin
            case (session_end)
                END_CONFIRM_FAULT: begin
                    if ($urandom_range(0, 1)) begin
                        // bank 0 or one above 3, whose low bits may alias a good bank
                        mb = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(4, 255));
                        push_msg(OP_CONFIRM, mb, $urandom);
                    end else begin
                        do op = 3'($urandom_range(0, 7)); while (op == OP_CONFIRM);
                        push_msg(op, bank_sel, n_blocks);
                    end
                    faulted = 1'b1;
                end
                END_TOO_MANY: begin
                    // over the limit but within the counter, or a count wider than the counter
                    if (lim_final < COUNT_MAX && $urandom_range(0, 1))
                        num = $urandom_range(lim_final + 1, COUNT_MAX);
                    else
                        num = $urandom | (32'd1 << $urandom_range(COUNT_WIDTH, 31));
                    push_msg(OP_CONFIRM, bank_sel, num);
                    faulted = 1'b1;
                end
                default: push_msg(OP_CONFIRM, bank_sel, n_blocks);
            endcase
            wait_drained();
            // limits no longer matter once confirmed; still a new setting
            write_limit(CFG_LIMIT_ONE, LIMIT_WIDTH'($urandom_range(0, 511)));
            write_limit(CFG_LIMIT_TWO, LIMIT_WIDTH'($urandom_range(0, 511)));
            write_limit(CFG_LIMIT_THREE, LIMIT_WIDTH'($urandom_range(0, 511)));
            end_cfg();
        end

        // transfer: tick sends a block, ack retires it
        if (!faulted) begin
            for (k = 0; k < n_blocks && !faulted; k++) begin
                // no ack owed: messages are dropped
                if ($urandom_range(0, 5) == 0) push_noise(1'b0, 1'b1, 1'b1);
                push_tick();
                // ack owed: extra ticks are dropped
                if ($urandom_range(0, 5) == 0) push_noise(1'b1, 1'b0, 1'b1);
                if (k == err_at && session_end >= END_ACK_DATA && session_end <= END_ACK_OP) begin
                    case (session_end)
                        END_ACK_DATA: push_msg(OP_DATA_ERROR, bank_sel, k);
                        END_ACK_BANK: begin
                            do mb = 8'($urandom_range(0, 255)); while (mb == bank_sel);
                            push_msg(OP_BLOCK_ACK, mb, k);
                        end
                        END_ACK_ORDER:
                            push_msg(OP_BLOCK_ACK, bank_sel, k ^ (32'd1 << $urandom_range(0, 31)));
                        default: begin
                            do op = 3'($urandom_range(0, 7));
                            while (op == OP_BLOCK_ACK || op == OP_DATA_ERROR);
                            push_msg(op, bank_sel, k);
                        end
                    endcase
                    faulted = 1'b1;
                end else begin
                    push_msg(OP_BLOCK_ACK, bank_sel, k);
                end
            end
        end

        // all blocks acked: next tick sends BYE, station answers BYE (another op for a bye fault)
        if (!faulted) begin
            push_noise(1'b0, 1'b1, 1'b1);
            push_tick();
            repeat ($urandom_range(1, 5)) push_noise(1'b1, 1'b0, 1'b1);
            if (session_end == END_BYE_FAULT) begin
                do op = 3'($urandom_range(0, 7)); while (op == OP_BYE);
                push_msg(op, 8'($urandom_range(0, 255)), $urandom);
            end else begin
                push_msg(OP_BYE, 8'($urandom_range(0, 255)), $urandom);
            end
        end

        // success or error phase: only OK acts, then done ignores all
        repeat ($urandom_range(2, 8)) push_noise(1'b1, 1'b1, 1'b0);
        push_answer(ANS_OK);
        repeat ($urandom_range(3, 8)) push_noise(1'b1, 1'b1, 1'b1);
        // short sessions are topped up with events the done phase ignores
        while (events_accepted + pending_events.size() < ITEM_TARGET)
            push_noise(1'b1, 1'b1, 1'b1);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Run: %0d events, %0d results checked, %0d blocks planned on bank %0d",
                 events_accepted, results_seen, n_blocks, bank_sel);
        $display("Session ending %s, final phase %0d, error code %0d, %0d mismatches",
                 session_end.name(), ph, err, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ backup_transfer_protocol_fsm_core.f @@
hw/rtl/btp_pkg.sv
hw/rtl/btp_in_stage.sv
hw/rtl/btp_fsm.sv
hw/rtl/btp_out_stage.sv
hw/rtl/backup_transfer_protocol_fsm_core.sv
hw/rtl/btp_checker.sv
tb/sv/backup_transfer_protocol_fsm_core_tb.sv
